@@ rtl/core/tds_pkg.sv @@
// Shared types and constants for the TIFF dimension sniffer.
package tds_pkg;

  // Tag numbers and field types of interest
  localparam logic [15:0] TAG_WIDTH    = 16'h0100;
  localparam logic [15:0] TAG_HEIGHT   = 16'h0101;
  localparam logic [15:0] TYPE_SHORT   = 16'h0003;
  localparam logic [15:0] TYPE_LONG    = 16'h0004;
  localparam logic [7:0]  ORDER_LITTLE = 8'h49;

  // Directory offsets below this cannot be reached without a rewind
  localparam logic [31:0] MIN_DIR_OFFSET = 32'd8;
  localparam logic [31:0] POS_MAX        = 32'hFFFF_FFFF;

  // Last byte of a 12-byte directory entry
  localparam logic [3:0] ENTRY_LAST_IDX = 4'd11;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        header_ok;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } out_item_t;

endpackage

@@ rtl/core/tiff_dimension_sniffer_core.sv @@
// Streaming TIFF header parser that reports image width and height.
//
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  tds_pkg::in_item_t  (one file byte)
//  out_     output     out_valid/out_stall tds_pkg::out_item_t (dimensions)
//
// One byte is taken every cycle while in_stall is low; each byte updates the parse state in one pass.
// A result is registered into the output register, or into the skid register while out_ is stalled.
// A two-deep output (result register plus skid register) keeps bytes flowing
// while a result waits; in_stall rises only when both are full.
// Reset (rst_n low, synchronous) returns to the header phase, empties the output.
// The final byte of a file returns the parse state to its reset values.
module tiff_dimension_sniffer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  tds_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output tds_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SKIP,
    PH_COUNT,
    PH_ENTRY,
    PH_DONE
  } phase_t;

  // Parse state
  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        be_r, be_nxt;
  logic [31:0] dir_off_r, dir_off_nxt;
  logic [15:0] entry_total_r, entry_total_nxt;
  logic [15:0] entries_done_r, entries_done_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] tag_r, tag_nxt;
  logic [15:0] type_r, type_nxt;
  logic [31:0] value_r, value_nxt;
  logic        w_seen_r, w_seen_nxt;
  logic        h_seen_r, h_seen_nxt;
  logic [31:0] w_val_r, w_val_nxt;
  logic [31:0] h_val_r, h_val_nxt;
  logic        given_r, given_nxt;

  // Output register and skid register
  logic               out_valid_r, out_valid_nxt;
  tds_pkg::out_item_t out_data_r, out_data_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  tds_pkg::out_item_t skid_data_r, skid_data_nxt;

  logic               in_xfer;
  logic               res_valid;
  tds_pkg::out_item_t res;

  // Add byte b as byte k of a multi-byte value in the chosen order
  function automatic logic [31:0] gather(input logic [31:0] acc, input logic [7:0] b,
                                         input logic [1:0] k, input logic big);
    logic [31:0] base;
    base = (k == 2'd0) ? 32'd0 : acc;
    if (big) begin
      return {base[23:0], b};
    end
    return base | ({24'd0, b} << {k, 3'b000});
  endfunction

  assign in_stall  = skid_valid_r;
  assign in_xfer   = in_valid && !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Advance the parse state by one byte
  always_comb begin
    phase_t      ph;
    logic [31:0] g;
    logic        emit;
    logic        ok;
    ph               = phase_r;
    g                = '0;
    emit             = 1'b0;
    ok               = 1'b0;
    phase_nxt        = phase_r;
    pos_nxt          = pos_r;
    be_nxt           = be_r;
    dir_off_nxt      = dir_off_r;
    entry_total_nxt  = entry_total_r;
    entries_done_nxt = entries_done_r;
    idx_nxt          = idx_r;
    tag_nxt          = tag_r;
    type_nxt         = type_r;
    value_nxt        = value_r;
    w_seen_nxt       = w_seen_r;
    h_seen_nxt       = h_seen_r;
    w_val_nxt        = w_val_r;
    h_val_nxt        = h_val_r;
    given_nxt        = given_r;
    res              = '0;

    if (in_xfer) begin
      // Enter the count phase when the skip reaches the directory
      if (phase_r == PH_SKIP && pos_r == dir_off_r) begin
        ph = PH_COUNT;
      end
      phase_nxt = ph;

      unique case (ph)
        PH_HEADER: begin
          if (pos_r == 32'd0) begin
            be_nxt = (in_data.data_byte != tds_pkg::ORDER_LITTLE);
          end
          if (pos_r >= 32'd4 && pos_r <= 32'd7) begin
            dir_off_nxt = gather(dir_off_r, in_data.data_byte, pos_r[1:0], be_nxt);
          end
          if (pos_r >= 32'd7) begin
            if (dir_off_nxt < tds_pkg::MIN_DIR_OFFSET) begin
              emit = 1'b1;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
        PH_COUNT: begin
          g = gather({16'd0, entry_total_r}, in_data.data_byte, {1'b0, idx_r[0]}, be_r);
          entry_total_nxt = g[15:0];
          if (idx_r >= 4'd1) begin
            idx_nxt   = 4'd0;
            phase_nxt = PH_ENTRY;
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        PH_ENTRY: begin
          if (idx_r < 4'd2) begin
            g       = gather({16'd0, tag_r}, in_data.data_byte, {1'b0, idx_r[0]}, be_r);
            tag_nxt = g[15:0];
          end else if (idx_r < 4'd4) begin
            g        = gather({16'd0, type_r}, in_data.data_byte, {1'b0, idx_r[0]}, be_r);
            type_nxt = g[15:0];
          end else if (idx_r >= 4'd8) begin
            value_nxt = gather(value_r, in_data.data_byte, idx_r[1:0], be_r);
          end
          if (idx_r >= tds_pkg::ENTRY_LAST_IDX) begin
            idx_nxt = 4'd0;
            // Close the entry: mark a width or height tag as seen, take its value if SHORT or LONG
            if (tag_r == tds_pkg::TAG_WIDTH) begin
              w_seen_nxt = 1'b1;
              if (type_r == tds_pkg::TYPE_SHORT) begin
                w_val_nxt = be_r ? {16'd0, value_nxt[31:16]} : {16'd0, value_nxt[15:0]};
              end else if (type_r == tds_pkg::TYPE_LONG) begin
                w_val_nxt = value_nxt;
              end
            end else if (tag_r == tds_pkg::TAG_HEIGHT) begin
              h_seen_nxt = 1'b1;
              if (type_r == tds_pkg::TYPE_SHORT) begin
                h_val_nxt = be_r ? {16'd0, value_nxt[31:16]} : {16'd0, value_nxt[15:0]};
              end else if (type_r == tds_pkg::TYPE_LONG) begin
                h_val_nxt = value_nxt;
              end
            end
            entries_done_nxt = entries_done_r + 16'd1;
            if ((w_seen_nxt && h_seen_nxt) || entries_done_nxt >= entry_total_r) begin
              emit = 1'b1;
            end
          end else begin
            idx_nxt = idx_r + 4'd1;
          end
        end
        default: begin
          // Skip and done phases only count bytes
        end
      endcase

      if (emit) begin
        given_nxt = 1'b1;
        phase_nxt = PH_DONE;
      end

      // Saturate the byte position
      if (pos_r != tds_pkg::POS_MAX) begin
        pos_nxt = pos_r + 32'd1;
      end

      // End of file: report if nothing was reported, then start over
      if (in_data.last_byte) begin
        if (!given_r) begin
          emit = 1'b1;
        end
      end

      ok                 = w_seen_nxt && h_seen_nxt;
      res.header_ok      = ok;
      res.image_width    = ok ? w_val_nxt : 32'd0;
      res.image_height   = ok ? h_val_nxt : 32'd0;

      if (in_data.last_byte) begin
        phase_nxt        = PH_HEADER;
        pos_nxt          = '0;
        be_nxt           = 1'b0;
        dir_off_nxt      = '0;
        entry_total_nxt  = '0;
        entries_done_nxt = '0;
        idx_nxt          = '0;
        tag_nxt          = '0;
        type_nxt         = '0;
        value_nxt        = '0;
        w_seen_nxt       = 1'b0;
        h_seen_nxt       = 1'b0;
        w_val_nxt        = '0;
        h_val_nxt        = '0;
        given_nxt        = 1'b0;
      end
    end
    res_valid = emit;
  end

  // Steer results into the output register or the skid register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = res_valid;
        out_data_nxt  = res;
      end
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HEADER;
      pos_r          <= '0;
      be_r           <= 1'b0;
      dir_off_r      <= '0;
      entry_total_r  <= '0;
      entries_done_r <= '0;
      idx_r          <= '0;
      tag_r          <= '0;
      type_r         <= '0;
      value_r        <= '0;
      w_seen_r       <= 1'b0;
      h_seen_r       <= 1'b0;
      w_val_r        <= '0;
      h_val_r        <= '0;
      given_r        <= 1'b0;
      out_valid_r    <= 1'b0;
      skid_valid_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      pos_r          <= pos_nxt;
      be_r           <= be_nxt;
      dir_off_r      <= dir_off_nxt;
      entry_total_r  <= entry_total_nxt;
      entries_done_r <= entries_done_nxt;
      idx_r          <= idx_nxt;
      tag_r          <= tag_nxt;
      type_r         <= type_nxt;
      value_r        <= value_nxt;
      w_seen_r       <= w_seen_nxt;
      h_seen_r       <= h_seen_nxt;
      w_val_r        <= w_val_nxt;
      h_val_r        <= h_val_nxt;
      given_r        <= given_nxt;
      out_valid_r    <= out_valid_nxt;
      skid_valid_r   <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

endmodule

@@ rtl/core/tds_core_chk.sv @@
// Port-level checker for the TIFF dimension sniffer, bound to tiff_dimension_sniffer_core.
module tds_core_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input tds_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input tds_pkg::out_item_t out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Drop sizes on a failed header
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.header_ok |->
      out_data.image_width == 32'd0 && out_data.image_height == 32'd0)
    else $error("failed header carries nonzero sizes");

  // Stall input only behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without a stalled result");

  // Hold a stalled input byte
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input byte changed or dropped");

  // Empty the output after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output not empty after reset");

endmodule

bind tiff_dimension_sniffer_core tds_core_chk u_tds_core_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/tds_dim_scoreboard.sv @@
// Byte-level model of the TIFF dimension sniffer and its result scoreboard.
package tds_dim_check_pkg;

  typedef enum logic [2:0] {
    SCAN_HEADER,
    SCAN_SKIP,
    SCAN_COUNT,
    SCAN_ENTRY,
    SCAN_DONE
  } scan_phase_t;

  localparam int unsigned MAX_REPORTS = 10;

  class tiff_dim_scoreboard;
    // Parser state, mirrored byte by byte
    logic [31:0] pos;
    logic        big_endian;
    scan_phase_t phase;
    logic [31:0] dir_offset;
    logic [15:0] entry_total;
    logic [15:0] entries_done;
    logic [3:0]  entry_idx;
    logic [15:0] tag_word;
    logic [15:0] kind_word;
    logic [31:0] value_word;
    logic        width_seen;
    logic        height_seen;
    logic [31:0] width_value;
    logic [31:0] height_value;
    logic        reported;

    tds_pkg::out_item_t expected_dims[$];
    int unsigned bytes_seen;
    int unsigned files_seen;
    int unsigned dims_checked;
    int unsigned mismatches;

    function new();
      clear_parse();
    endfunction

    function void clear_parse();
      pos          = '0;
      big_endian   = 1'b0;
      phase        = SCAN_HEADER;
      dir_offset   = '0;
      entry_total  = '0;
      entries_done = '0;
      entry_idx    = '0;
      tag_word     = '0;
      kind_word    = '0;
      value_word   = '0;
      width_seen   = 1'b0;
      height_seen  = 1'b0;
      width_value  = '0;
      height_value = '0;
      reported     = 1'b0;
    endfunction

    // Merge byte b as byte k of a multi-byte field in the current byte order
    function logic [31:0] merge_byte(logic [31:0] acc, logic [7:0] b, int unsigned k);
      logic [31:0] sum;
      sum = (k == 0) ? '0 : acc;
      if (big_endian) return {sum[23:0], b};
      return sum | ({24'b0, b} << (8 * (k % 4)));
    endfunction

    // Queue the dimension report and stop parsing this file
    function void post_dims();
      tds_pkg::out_item_t d;
      d.header_ok    = width_seen && height_seen;
      d.image_width  = d.header_ok ? width_value : '0;
      d.image_height = d.header_ok ? height_value : '0;
      expected_dims.push_back(d);
      reported = 1'b1;
      phase    = SCAN_DONE;
    endfunction

    // Apply a completed 12-byte directory entry
    function void close_entry();
      logic [31:0] v;
      logic        sized;
      sized = (kind_word == tds_pkg::TYPE_SHORT) || (kind_word == tds_pkg::TYPE_LONG);
      if (kind_word == tds_pkg::TYPE_SHORT)
        v = big_endian ? {16'b0, value_word[31:16]} : {16'b0, value_word[15:0]};
      else
        v = value_word;
      if (tag_word == tds_pkg::TAG_WIDTH) begin
        width_seen = 1'b1;
        if (sized) width_value = v;
      end else if (tag_word == tds_pkg::TAG_HEIGHT) begin
        height_seen = 1'b1;
        if (sized) height_value = v;
      end
      entries_done = entries_done + 16'd1;
    endfunction

    // Advance the model by one accepted byte
    function void note_byte(tds_pkg::in_item_t it);
      logic [31:0] merged;
      int unsigned k;
      bit          posted;
      posted = 1'b0;
      bytes_seen++;
      if (phase == SCAN_SKIP && pos == dir_offset) phase = SCAN_COUNT;
      case (phase)
        SCAN_HEADER: begin
          if (pos == 0) big_endian = (it.data_byte != tds_pkg::ORDER_LITTLE);
          if (pos >= 4 && pos <= 7) dir_offset = merge_byte(dir_offset, it.data_byte, pos - 4);
          if (pos >= 7) begin
            if (dir_offset < tds_pkg::MIN_DIR_OFFSET) begin
              post_dims();
              posted = 1'b1;
            end else begin
              phase = SCAN_SKIP;
            end
          end
        end
        SCAN_COUNT: begin
          merged      = merge_byte({16'b0, entry_total}, it.data_byte, 32'(entry_idx));
          entry_total = merged[15:0];
          entry_idx++;
          if (entry_idx >= 4'd2) begin
            entry_idx = '0;
            phase     = SCAN_ENTRY;
          end
        end
        SCAN_ENTRY: begin
          k = 32'(entry_idx);
          if (k < 2) begin
            merged   = merge_byte({16'b0, tag_word}, it.data_byte, k);
            tag_word = merged[15:0];
          end else if (k < 4) begin
            merged    = merge_byte({16'b0, kind_word}, it.data_byte, k - 2);
            kind_word = merged[15:0];
          end else if (k >= 8) begin
            value_word = merge_byte(value_word, it.data_byte, k - 8);
          end
          if (k >= 32'(tds_pkg::ENTRY_LAST_IDX)) begin
            entry_idx = '0;
            close_entry();
            if ((width_seen && height_seen) || entries_done >= entry_total) begin
              post_dims();
              posted = 1'b1;
            end
          end else begin
            entry_idx = entry_idx + 4'd1;
          end
        end
        default: ;
      endcase
      if (pos != tds_pkg::POS_MAX) pos++;
      // Final byte: report if nothing went out yet, then start over
      if (it.last_byte) begin
        files_seen++;
        if (!posted && !reported) post_dims();
        clear_parse();
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("MISMATCH: %s", msg);
    endfunction

    // Compare one accepted result against the oldest expected report
    function void check_dims(tds_pkg::out_item_t got);
      tds_pkg::out_item_t want;
      if (expected_dims.size() == 0) begin
        flag($sformatf("unexpected report ok=%0b w=%0d h=%0d",
                       got.header_ok, got.image_width, got.image_height));
        return;
      end
      want = expected_dims.pop_front();
      dims_checked++;
      if (got.header_ok !== want.header_ok || got.image_width !== want.image_width ||
          got.image_height !== want.image_height)
        flag($sformatf("report %0d: expected ok=%0b w=%0d h=%0d, got ok=%0b w=%0d h=%0d",
                       dims_checked, want.header_ok, want.image_width, want.image_height,
                       got.header_ok, got.image_width, got.image_height));
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
// Top-level testbench for tiff_dimension_sniffer_core with directed and random byte streams.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BYTE_TARGET  = 1000;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned IDLE_PCT     = 8;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  tds_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  tds_pkg::out_item_t out_data;

  bit                                    calm   = 1'b0;
  int unsigned                           cycles = 0;
  logic [7:0]                            image_q[$];
  bit                                    image_big;
  tds_dim_check_pkg::tiff_dim_scoreboard book = new();

  tiff_dimension_sniffer_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Stall the result channel at random and check every result transfer
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) book.check_dims(out_data);
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Hold one byte on the input until the transfer happens, after random idle cycles
  task automatic push_byte(input tds_pkg::in_item_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_byte(it);
  endtask

  // Append the low n bytes of v in the file's byte order
  task automatic put_field(input logic [31:0] v, input int unsigned n);
    logic [31:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      s = image_big ? (v >> (8 * (n - 1 - i))) : (v >> (8 * i));
      image_q.push_back(s[7:0]);
    end
  endtask

  // Stream the first keep bytes of the built file, marking the final one
  task automatic send_image(input int unsigned keep);
    tds_pkg::in_item_t it;
    for (int unsigned i = 0; i < keep; i++) begin
      it.data_byte = image_q[i];
      it.last_byte = (i == keep - 1);
      push_byte(it);
    end
  endtask

  // Build a mostly well-formed file with random content
  task automatic build_tiff();
    logic [31:0] offset;
    logic [15:0] tag;
    logic [15:0] kind;
    logic [7:0]  mark;
    int unsigned roll;
    int unsigned count;
    int unsigned n_entries;
    image_q.delete();
    image_big = 1'($urandom_range(1));
    // byte-order mark: any byte other than 'I' selects big endian
    mark = 8'($urandom);
    if (mark == tds_pkg::ORDER_LITTLE) mark = 8'h4D;
    if (!image_big) image_q.push_back(tds_pkg::ORDER_LITTLE);
    else if ($urandom_range(3) == 0) image_q.push_back(mark);
    else image_q.push_back(8'h4D);
    image_q.push_back(image_q[0]);
    put_field(32'd42, 2);
    // directory offset: invalid, adjacent, far away or a short skip
    roll = $urandom_range(99);
    if (roll < 10) offset = $urandom_range(7);
    else if (roll < 25) offset = tds_pkg::MIN_DIR_OFFSET;
    else if (roll < 30) offset = $urandom;
    else offset = tds_pkg::MIN_DIR_OFFSET + $urandom_range(24);
    put_field(offset, 4);
    if (offset <= 64) begin
      while (image_q.size() < offset) image_q.push_back(8'($urandom));
    end
    // entry count: mostly a few, sometimes zero or near the top
    roll = $urandom_range(99);
    if (roll < 10) count = 0;
    else if (roll < 15) count = 32'hFFFF - $urandom_range(3);
    else count = 1 + $urandom_range(4);
    put_field(count, 2);
    n_entries = (count == 0) ? 1 : ((count > 6) ? 6 : count);
    for (int unsigned e = 0; e < n_entries; e++) begin
      roll = $urandom_range(99);
      if (roll < 40) tag = tds_pkg::TAG_WIDTH;
      else if (roll < 80) tag = tds_pkg::TAG_HEIGHT;
      else tag = 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 35) kind = tds_pkg::TYPE_SHORT;
      else if (roll < 70) kind = tds_pkg::TYPE_LONG;
      else kind = 16'($urandom);
      put_field(32'(tag), 2);
      put_field(32'(kind), 2);
      put_field($urandom, 4);
      put_field($urandom, 4);
    end
    repeat ($urandom_range(6)) image_q.push_back(8'($urandom));
  endtask

  // Build a file of random bytes
  task automatic build_noise();
    image_q.delete();
    repeat (1 + $urandom_range(23)) image_q.push_back(8'($urandom));
  endtask

  initial begin
    int unsigned keep;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // File ends inside the header
    image_q = {tds_pkg::ORDER_LITTLE, tds_pkg::ORDER_LITTLE, 8'h2A};
    send_image(3);

    // Offset below 4, final byte lands on the report byte
    image_big = 1'b1;
    image_q   = {8'h4D, 8'h4D};
    put_field(32'd42, 2);
    put_field(32'd3, 4);
    send_image(image_q.size());

    // Offset needing a rewind; trailing bytes after the report are ignored
    image_q = {8'h4D, 8'h4D};
    put_field(32'd42, 2);
    put_field(32'd5, 4);
    image_q.push_back(8'hFF);
    image_q.push_back(8'h00);
    send_image(image_q.size());

    // Directory right after the header with a zero count: one entry still read
    image_big = 1'b0;
    image_q   = {tds_pkg::ORDER_LITTLE, tds_pkg::ORDER_LITTLE};
    put_field(32'd42, 2);
    put_field(tds_pkg::MIN_DIR_OFFSET, 4);
    put_field(32'd0, 2);
    put_field(32'(tds_pkg::TAG_WIDTH), 2);
    put_field(32'(tds_pkg::TYPE_SHORT), 2);
    put_field(32'd1, 4);
    put_field(32'hFFFF_FFFF, 4);
    send_image(image_q.size());

    // Random files, with a stretch of back-to-back traffic in the middle
    while (book.bytes_seen < BYTE_TARGET) begin
      calm = (book.bytes_seen >= 400 && book.bytes_seen < 600);
      if ($urandom_range(99) < 85) build_tiff();
      else build_noise();
      keep = image_q.size();
      if ($urandom_range(99) < 15) keep = 1 + $urandom_range(image_q.size() - 1);
      send_image(keep);
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding reports, then let the pipeline settle
    while (book.expected_dims.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.expected_dims.size() != 0)
      book.flag($sformatf("%0d reports never arrived", book.expected_dims.size()));

    $display("Streamed %0d bytes in %0d files; checked %0d dimension reports, %0d mismatches.",
             book.bytes_seen, book.files_seen, book.dims_checked, book.mismatches);
    if (book.mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
